// ===== rtl/core/rmt_pkg.sv =====
// Shared types, constants and helper functions for the regret matching trainer.
// Used by rmt_divider and regret_matching_trainer; depends on nothing.
`timescale 1ns / 1ps

package rmt_pkg;

  // Game and sizing constants
  localparam int unsigned NUM_ACTIONS     = 3;
  localparam int unsigned ACT_BITS        = 2;
  localparam int unsigned PROB_BITS_DEF   = 16;
  localparam int unsigned REGRET_BITS_DEF = 24;
  localparam int unsigned TOTAL_BITS      = 48;
  // sum of three strategy totals
  localparam int unsigned DIV_BITS        = TOTAL_BITS + 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPP_ROCK  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPP_PAPER = 1'b1;

  typedef logic [ACT_BITS-1:0] action_t;

  // Action codes
  localparam action_t ACT_ROCK     = 2'd0;
  localparam action_t ACT_PAPER    = 2'd1;
  localparam action_t ACT_SCISSORS = 2'd2;

  // Utility of playing a against opp: 0 on a tie, +1 for the action that beats opp, else -1
  function automatic logic signed [2:0] util(action_t a, action_t opp);
    action_t up;
    up = (opp == ACT_SCISSORS) ? ACT_ROCK : opp + 2'd1;
    if (a == opp) begin
      return 3'sd0;
    end else if (a == up) begin
      return 3'sd1;
    end
    return -3'sd1;
  endfunction

  // Regret increment of action a given own and opponent actions
  function automatic logic signed [2:0] util_delta(action_t a, action_t mine, action_t opp);
    logic signed [2:0] ua;
    logic signed [2:0] um;
    ua = util(a, opp);
    um = util(mine, opp);
    return ua - um;
  endfunction

endpackage

// ===== rtl/core/rmt_divider.sv =====
// Shared bit-serial restoring divider: quo = floor(num * 2^(QW-1) / den), num <= den.
// One quotient bit per cycle. Depends on rmt_pkg.
`timescale 1ns / 1ps

module rmt_divider #(
  parameter int unsigned DW = rmt_pkg::DIV_BITS,
  parameter int unsigned QW = rmt_pkg::PROB_BITS_DEF + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);
  import rmt_pkg::*;

  localparam int unsigned CW = $clog2(QW);
  localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [QW-1:0] quo_q, quo_d;

  logic [DW:0]   trial;
  logic          ge;

  // One restoring step: first step compares unshifted, later ones shift left
  always_comb begin
    trial = (cnt_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
    ge    = trial >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? trial - {1'b0, den_q} : trial;
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // Checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (den_i != '0) && (num_i <= den_i))
    else $error("divider operands out of range");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> quo_q <= (QW'(1) << (QW - 1)))
    else $error("divider quotient above one");

endmodule

// ===== rtl/core/regret_matching_trainer.sv =====
// Regret matching trainer for rock-paper-scissors: sequencer, state and result register.
// Depends on rmt_pkg and rmt_divider (one shared divider for all six divisions).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one training round per beat:
//   two uniform random fractions. Output channel (out_valid_o / out_stall_i)
//   returns one beat per round: both sampled actions, the three regrets after
//   the round and the average strategy.
//   Configuration: cfg_we_i writes the opponent probability selected by
//   cfg_idx_i (0 rock, 1 paper); scissors takes the remainder.
//   Timing: one round at a time, each division holding the shared divider until
//   its quotient is done. The result is loaded in the final step and the next
//   round can be taken once the sequencer is back in idle; fractions are Q0.16
//   at the default PROB_BITS. With no positive regret the strategy divisions
//   are skipped.
//   in_stall_o stays high from the accepting edge until the result is loaded.
//   Reset clears the regrets and strategy totals and loads both opponent
//   probabilities with about 0.33. If the receiver stalls, the result waits in
//   the output register; the next round is taken meanwhile and holds in its
//   final step until the register frees.
`timescale 1ns / 1ps

module regret_matching_trainer #(
  parameter int unsigned PROB_BITS   = rmt_pkg::PROB_BITS_DEF,
  parameter int unsigned REGRET_BITS = rmt_pkg::REGRET_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [rmt_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [PROB_BITS-1:0]                cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [PROB_BITS-1:0]                rand_self_i,
  input  logic [PROB_BITS-1:0]                rand_opponent_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rmt_pkg::action_t                    self_action_o,
  output rmt_pkg::action_t                    opponent_action_o,
  output logic signed [REGRET_BITS-1:0]       regret_rock_o,
  output logic signed [REGRET_BITS-1:0]       regret_paper_o,
  output logic signed [REGRET_BITS-1:0]       regret_scissors_o,
  output logic [PROB_BITS-1:0]                avg_rock_o,
  output logic [PROB_BITS-1:0]                avg_paper_o,
  output logic [PROB_BITS-1:0]                avg_scissors_o
);
  import rmt_pkg::*;

  localparam int unsigned QW = PROB_BITS + 1;
  localparam int unsigned NW = REGRET_BITS + 1;
  localparam int unsigned TW = TOTAL_BITS;
  localparam int unsigned DW = DIV_BITS;

  localparam logic [QW-1:0] PROB_ONE   = QW'(1) << PROB_BITS;
  localparam logic [QW-1:0] PROB_THIRD = QW'((1 << PROB_BITS) / NUM_ACTIONS);
  localparam logic [PROB_BITS-1:0] AVG_MAX = {PROB_BITS{1'b1}};
  localparam logic [TW-1:0] TOTAL_MAX = {TW{1'b1}};
  // about 0.33, rounded to nearest
  localparam logic [PROB_BITS-1:0] OPP_RESET =
    PROB_BITS'((33 * (1 << PROB_BITS) + 50) / 100);
  localparam logic signed [NW-1:0] REG_HI =
    NW'((longint'(1) << (REGRET_BITS - 1)) - 1);
  localparam logic signed [NW-1:0] REG_LO = -REG_HI - NW'(1);
  localparam action_t IDX_LAST = ACT_BITS'(NUM_ACTIONS - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STRAT = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_TSUM  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_AVG   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]     state_q, state_d;
  action_t        idx_q, idx_d;
  logic           issued_q, issued_d;

  logic [PROB_BITS-1:0] opp_rock_q, opp_rock_d;
  logic [PROB_BITS-1:0] opp_paper_q, opp_paper_d;

  logic [PROB_BITS-1:0] r_self_q, r_self_d;
  logic [PROB_BITS-1:0] r_opp_q, r_opp_d;
  logic [NW-1:0]        norm_q, norm_d;
  logic [DW-1:0]        tsum_q, tsum_d;
  action_t              self_act_q, self_act_d;
  action_t              opp_act_q, opp_act_d;

  logic signed [REGRET_BITS-1:0] regret_q [NUM_ACTIONS];
  logic signed [REGRET_BITS-1:0] regret_d [NUM_ACTIONS];
  logic [QW-1:0]                 strat_q  [NUM_ACTIONS];
  logic [QW-1:0]                 strat_d  [NUM_ACTIONS];
  logic [TW-1:0]                 total_q  [NUM_ACTIONS];
  logic [TW-1:0]                 total_d  [NUM_ACTIONS];
  logic [PROB_BITS-1:0]          avg_q    [NUM_ACTIONS];
  logic [PROB_BITS-1:0]          avg_d    [NUM_ACTIONS];

  // result register
  logic                          out_valid_q, out_valid_d;
  action_t                       out_self_q, out_self_d;
  action_t                       out_opp_q, out_opp_d;
  logic signed [REGRET_BITS-1:0] out_regret_q [NUM_ACTIONS];
  logic signed [REGRET_BITS-1:0] out_regret_d [NUM_ACTIONS];
  logic [PROB_BITS-1:0]          out_avg_q    [NUM_ACTIONS];
  logic [PROB_BITS-1:0]          out_avg_d    [NUM_ACTIONS];

  // divider hookup
  logic          div_start;
  logic [DW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [QW-1:0] div_quo;

  // datapath helpers
  logic [NW-1:0]   pos [NUM_ACTIONS];
  logic [NW-1:0]   norm_sum;
  logic [TW:0]     total_add;
  logic [TW-1:0]   total_sat;
  logic [QW+1:0]   strat_c0, strat_c1, strat_sum, r_self_ext;
  logic [PROB_BITS:0] opp_c0, opp_c1, r_opp_ext;
  action_t         self_pick, opp_pick;
  logic signed [2:0]    delta [NUM_ACTIONS];
  logic signed [NW-1:0] regret_new [NUM_ACTIONS];
  logic [PROB_BITS-1:0] avg_clamped;
  logic in_accept, out_accept;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Positive parts of the regrets and their sum
  always_comb begin
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      pos[a] = regret_q[a][REGRET_BITS-1] ? '0 : NW'(regret_q[a]);
    end
    norm_sum = pos[0] + pos[1] + pos[2];
  end

  // Saturating add of the current strategy into one total
  always_comb begin
    total_add = {1'b0, total_q[idx_q]} + (TW+1)'(strat_q[idx_q]);
    total_sat = total_add[TW] ? TOTAL_MAX : total_add[TW-1:0];
  end

  // Sampling of both actions by cumulative compare
  always_comb begin
    strat_c0   = (QW+2)'(strat_q[0]);
    strat_c1   = strat_c0 + (QW+2)'(strat_q[1]);
    strat_sum  = strat_c1 + (QW+2)'(strat_q[2]);
    r_self_ext = (QW+2)'(r_self_q);
    if (r_self_ext < strat_c0) begin
      self_pick = ACT_ROCK;
    end else if (r_self_ext < strat_c1) begin
      self_pick = ACT_PAPER;
    end else begin
      self_pick = ACT_SCISSORS;
    end
    opp_c0    = {1'b0, opp_rock_q};
    opp_c1    = opp_c0 + {1'b0, opp_paper_q};
    r_opp_ext = {1'b0, r_opp_q};
    if (r_opp_ext < opp_c0) begin
      opp_pick = ACT_ROCK;
    end else if (r_opp_ext < opp_c1) begin
      opp_pick = ACT_PAPER;
    end else begin
      opp_pick = ACT_SCISSORS;
    end
  end

  // Saturating regret update, one lane per action
  always_comb begin
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      delta[a] = util_delta(ACT_BITS'(a), self_pick, opp_pick);
      regret_new[a] = {regret_q[a][REGRET_BITS-1], regret_q[a]} +
                      {{(NW-3){delta[a][2]}}, delta[a]};
      if (regret_new[a] > REG_HI) begin
        regret_new[a] = REG_HI;
      end else if (regret_new[a] < REG_LO) begin
        regret_new[a] = REG_LO;
      end
    end
  end

  // Divider operands: strategy phase divides regrets, average phase divides totals
  always_comb begin
    if (state_q == S_STRAT) begin
      div_num = DW'(pos[idx_q]);
      div_den = DW'(norm_q);
    end else begin
      div_num = DW'(total_q[idx_q]);
      div_den = tsum_q;
    end
    avg_clamped = div_quo[PROB_BITS] ? AVG_MAX : div_quo[PROB_BITS-1:0];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    issued_d    = issued_q;
    r_self_d    = r_self_q;
    r_opp_d     = r_opp_q;
    norm_d      = norm_q;
    tsum_d      = tsum_q;
    self_act_d  = self_act_q;
    opp_act_d   = opp_act_q;
    regret_d    = regret_q;
    strat_d     = strat_q;
    total_d     = total_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q;
    out_self_d  = out_self_q;
    out_opp_d   = out_opp_q;
    out_regret_d = out_regret_q;
    out_avg_d   = out_avg_q;
    div_start   = 1'b0;

    if (out_accept) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          r_self_d = rand_self_i;
          r_opp_d  = rand_opponent_i;
          norm_d   = norm_sum;
          idx_d    = '0;
          issued_d = 1'b0;
          if (norm_sum == '0) begin
            for (int a = 0; a < NUM_ACTIONS; a++) begin
              strat_d[a] = PROB_THIRD;
            end
            state_d = S_ACC;
          end else begin
            state_d = S_STRAT;
          end
        end
      end
      S_STRAT: begin
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          strat_d[idx_q] = div_quo;
          issued_d = 1'b0;
          if (idx_q == IDX_LAST) begin
            idx_d   = '0;
            state_d = S_ACC;
          end else begin
            idx_d = idx_q + ACT_BITS'(1);
          end
        end
      end
      S_ACC: begin
        total_d[idx_q] = total_sat;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          tsum_d  = '0;
          state_d = S_TSUM;
        end else begin
          idx_d = idx_q + ACT_BITS'(1);
        end
      end
      S_TSUM: begin
        tsum_d = tsum_q + DW'(total_q[idx_q]);
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = S_UPD;
        end else begin
          idx_d = idx_q + ACT_BITS'(1);
        end
      end
      S_UPD: begin
        self_act_d = self_pick;
        opp_act_d  = opp_pick;
        for (int a = 0; a < NUM_ACTIONS; a++) begin
          regret_d[a] = regret_new[a][REGRET_BITS-1:0];
        end
        issued_d = 1'b0;
        idx_d    = '0;
        if (tsum_q == '0) begin
          for (int a = 0; a < NUM_ACTIONS; a++) begin
            avg_d[a] = PROB_THIRD[PROB_BITS-1:0];
          end
          state_d = S_FIN;
        end else begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          avg_d[idx_q] = avg_clamped;
          issued_d = 1'b0;
          if (idx_q == IDX_LAST) begin
            idx_d   = '0;
            state_d = S_FIN;
          end else begin
            idx_d = idx_q + ACT_BITS'(1);
          end
        end
      end
      S_FIN: begin
        // load the result register once it is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_self_d   = self_act_q;
          out_opp_d    = opp_act_q;
          out_regret_d = regret_q;
          out_avg_d    = avg_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_comb begin
    opp_rock_d  = opp_rock_q;
    opp_paper_d = opp_paper_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OPP_ROCK:  opp_rock_d  = cfg_data_i;
        CFG_OPP_PAPER: opp_paper_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      opp_rock_q  <= OPP_RESET;
      opp_paper_q <= OPP_RESET;
      for (int a = 0; a < NUM_ACTIONS; a++) begin
        regret_q[a] <= '0;
        total_q[a]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      opp_rock_q  <= opp_rock_d;
      opp_paper_q <= opp_paper_d;
      regret_q    <= regret_d;
      total_q     <= total_d;
    end
  end

  // Working registers and result payload, no reset
  always_ff @(posedge clk_i) begin
    r_self_q     <= r_self_d;
    r_opp_q      <= r_opp_d;
    norm_q       <= norm_d;
    tsum_q       <= tsum_d;
    self_act_q   <= self_act_d;
    opp_act_q    <= opp_act_d;
    strat_q      <= strat_d;
    avg_q        <= avg_d;
    out_self_q   <= out_self_d;
    out_opp_q    <= out_opp_d;
    out_regret_q <= out_regret_d;
    out_avg_q    <= out_avg_d;
  end

  rmt_divider #(
    .DW (DW),
    .QW (QW)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Ports
  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign self_action_o     = out_self_q;
  assign opponent_action_o = out_opp_q;
  assign regret_rock_o     = out_regret_q[0];
  assign regret_paper_o    = out_regret_q[1];
  assign regret_scissors_o = out_regret_q[2];
  assign avg_rock_o        = out_avg_q[0];
  assign avg_paper_o       = out_avg_q[1];
  assign avg_scissors_o    = out_avg_q[2];

  // Checks
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == S_STRAT) || (state_q == S_AVG)) && issued_q)
    else $error("divider result arrived outside a division phase");

  a_strat_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (strat_sum <= (QW+2)'(PROB_ONE)))
    else $error("current strategy sums above one");

  a_regret_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_UPD) |=>
      ($stable(regret_q[0]) && $stable(regret_q[1]) && $stable(regret_q[2])))
    else $error("regrets changed outside the update step");

  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ACC) |=>
      ($stable(total_q[0]) && $stable(total_q[1]) && $stable(total_q[2])))
    else $error("strategy totals changed outside the accumulate step");

endmodule
